// ===== hw/rtl/stereo_channel_mixer_with_clip_macros.svh =====
// Assertion macros used by the stereo mixer datapath RTL.
`ifndef STEREO_CHANNEL_MIXER_WITH_CLIP_MACROS_SVH
`define STEREO_CHANNEL_MIXER_WITH_CLIP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SCMIX_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mixer check failed");

// Next-cycle implication, checked outside reset.
`define SCMIX_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mixer check failed");

`endif

// ===== hw/rtl/scmix_pkg.sv =====
// Types and constants shared by the stereo mixer controller and datapath.
`default_nettype none

package scmix_pkg;

    localparam int SampleW = 16;
    localparam int VolW    = 8;
    localparam int SumW    = 32;
    localparam int AccW    = 19;
    localparam int MulBW   = 10;
    localparam int ProdW   = SumW + MulBW;
    localparam int FracSh  = 7;

    localparam logic [MulBW-1:0] UnityWeight = MulBW'(128);

    localparam logic signed [SumW-1:0] ClipMax75  = SumW'(32768 * 75 / 100);
    localparam logic signed [SumW-1:0] ClipMax875 = SumW'(32768 * 875 / 1000);
    localparam logic signed [SumW-1:0] ClipMaxFull = SumW'(32767);
    localparam logic signed [SumW-1:0] ClipMinFull = -SumW'(32768);

    localparam logic [7:0] CLIP_FULL = 8'd1;
    localparam logic [7:0] CLIP_875  = 8'd2;
    localparam logic [7:0] CLIP_75   = 8'd3;

    typedef enum logic [1:0] {
        CFG_MASTER_VOLUME = 2'd0,
        CFG_BOOST_LEVEL   = 2'd1,
        CFG_CLIP_MODE     = 2'd2,
        CFG_MUTE          = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_VOL  = 3'd1,
        OP_GAIN = 3'd2,
        OP_PANR = 3'd3,
        OP_PANL = 3'd4,
        OP_FINL = 3'd5,
        OP_FINR = 3'd6,
        OP_EMIT = 3'd7
    } t_op;

    typedef struct packed {
        logic load;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/stereo_channel_mixer_with_clip.sv =====
// Top level of the stereo channel mixer with clip limiter.
`default_nettype none

// Stereo channel mixer with clip limiter. Feed one word per channel: its
// signed sample, volume, gain, pan and an active flag; set last_channel on
// the final channel of a frame. Active channels are scaled by volume, then
// gain (128 is unity, each step a multiply and arithmetic shift right by 7)
// and added to the right sum weighted by pan and to the left sum weighted by
// 128 minus pan (pan above 128 gives a negative left weight). The word that
// carries last_channel closes the frame: both sums are multiplied by
// master_volume, shifted right by 7 minus boost_level, clamped as clip_mode
// selects (3: +-24576, 2: +-28672, 1: full 16-bit, else low 16 bits kept),
// zeroed if mute is set, and one stereo word leaves on the output channel.
// Sums wrap at 32 bits and clear after every frame. All arithmetic runs
// through a single shared multiplier, at most one product per cycle: an
// active channel runs the volume, gain, right pan and left pan products in
// turn, and unless it closes a frame the next word is taken during the left
// pan product; an inactive channel that does not close a frame needs no
// product and leaves the block idle. Closing a frame adds the left master
// product, the right master product and the output load, which waits while
// the output register still holds a word not yet taken; the next word is
// then taken only in the idle state that follows the output load. Write
// configuration only while the block is idle; writes take effect at the
// next clock edge.

module stereo_channel_mixer_with_clip (
    input  wire               i_clk,
    input  wire               i_rst_n,
    // input channel
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire signed [15:0] i_sample,
    input  wire [7:0]         i_channel_volume,
    input  wire [7:0]         i_channel_gain,
    input  wire [7:0]         i_pan_position,
    input  wire               i_active,
    input  wire               i_last_channel,
    // output channel
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic signed [15:0] o_left_out,
    output logic signed [15:0] o_right_out,
    // configuration write port
    input  wire               i_cfg_we,
    input  wire [1:0]         i_cfg_index,
    input  wire [7:0]         i_cfg_data
);

    scmix_pkg::t_cmd w_cmd;
    scmix_pkg::t_sts w_sts;

    // Sequence the shared multiplier and the frame close.
    scmix_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_active       (i_active),
        .i_last_channel (i_last_channel),
        .o_in_stall     (o_in_stall),
        .i_sts          (w_sts),
        .o_cmd          (w_cmd)
    );

    // Hold the item, accumulate the sums, finish and register the output word.
    scmix_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_sample         (i_sample),
        .i_channel_volume (i_channel_volume),
        .i_channel_gain   (i_channel_gain),
        .i_pan_position   (i_pan_position),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_left_out       (o_left_out),
        .o_right_out      (o_right_out)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/scmix_ctrl.sv =====
// Sequencing state machine of the stereo mixer.
`default_nettype none

module scmix_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire               i_active,
    input  wire               i_last_channel,
    output logic              o_in_stall,
    input  scmix_pkg::t_sts   i_sts,
    output scmix_pkg::t_cmd   o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_VOL  = 8'b0000_0010,
        S_GAIN = 8'b0000_0100,
        S_PANR = 8'b0000_1000,
        S_PANL = 8'b0001_0000,
        S_FINL = 8'b0010_0000,
        S_FINR = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } t_state;

    t_state r_state, n_state, w_take;
    logic   r_last, n_last;
    logic   w_ready, w_accept;

    // Accept in idle, or overlap with the last step of a non-closing word.
    assign w_ready    = (r_state == S_IDLE) || ((r_state == S_PANL) && !r_last);
    assign o_in_stall = !w_ready;
    assign w_accept   = i_in_valid && w_ready;

    always_comb begin
        if (i_active) begin
            w_take = S_VOL;
        end else if (i_last_channel) begin
            w_take = S_FINL;
        end else begin
            w_take = S_IDLE;
        end
    end

    always_comb begin
        n_state = r_state;
        n_last  = w_accept ? i_last_channel : r_last;
        o_cmd.load = w_accept;
        o_cmd.op   = scmix_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_take;
                end
            end
            S_VOL: begin
                o_cmd.op = scmix_pkg::OP_VOL;
                n_state  = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.op = scmix_pkg::OP_GAIN;
                n_state  = S_PANR;
            end
            S_PANR: begin
                o_cmd.op = scmix_pkg::OP_PANR;
                n_state  = S_PANL;
            end
            S_PANL: begin
                o_cmd.op = scmix_pkg::OP_PANL;
                if (r_last) begin
                    n_state = S_FINL;
                end else if (w_accept) begin
                    n_state = w_take;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FINL: begin
                o_cmd.op = scmix_pkg::OP_FINL;
                n_state  = S_FINR;
            end
            S_FINR: begin
                o_cmd.op = scmix_pkg::OP_FINR;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = scmix_pkg::OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/scmix_dp.sv =====
// Datapath of the stereo mixer: shared multiplier, sums, clip and output register.
`default_nettype none

`include "stereo_channel_mixer_with_clip_macros.svh"

module scmix_dp (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  scmix_pkg::t_cmd                   i_cmd,
    output scmix_pkg::t_sts                   o_sts,
    input  wire signed [scmix_pkg::SampleW-1:0] i_sample,
    input  wire [scmix_pkg::VolW-1:0]         i_channel_volume,
    input  wire [scmix_pkg::VolW-1:0]         i_channel_gain,
    input  wire [scmix_pkg::VolW-1:0]         i_pan_position,
    input  wire                               i_cfg_we,
    input  wire [1:0]                         i_cfg_index,
    input  wire [7:0]                         i_cfg_data,
    input  wire                               i_out_stall,
    output logic                              o_out_valid,
    output logic signed [scmix_pkg::SampleW-1:0] o_left_out,
    output logic signed [scmix_pkg::SampleW-1:0] o_right_out
);

    localparam int SW = scmix_pkg::SumW;
    localparam int BW = scmix_pkg::MulBW;
    localparam int OW = scmix_pkg::SampleW;

    // Final shift, clamp and mute of one scaled sum.
    function automatic logic [OW-1:0] finish_word(input logic [SW-1:0] prod,
                                                  input logic [2:0] boost,
                                                  input logic [7:0] mode,
                                                  input logic mute);
        logic signed [SW-1:0] v;
        logic [2:0]           sh;
        sh = 3'd7 - boost;
        v  = $signed(prod) >>> sh;
        unique case (mode)
            scmix_pkg::CLIP_75: begin
                if (v > scmix_pkg::ClipMax75) begin
                    v = scmix_pkg::ClipMax75;
                end else if (v < -scmix_pkg::ClipMax75) begin
                    v = -scmix_pkg::ClipMax75;
                end
            end
            scmix_pkg::CLIP_875: begin
                if (v > scmix_pkg::ClipMax875) begin
                    v = scmix_pkg::ClipMax875;
                end else if (v < -scmix_pkg::ClipMax875) begin
                    v = -scmix_pkg::ClipMax875;
                end
            end
            scmix_pkg::CLIP_FULL: begin
                if (v > scmix_pkg::ClipMaxFull) begin
                    v = scmix_pkg::ClipMaxFull;
                end else if (v < scmix_pkg::ClipMinFull) begin
                    v = scmix_pkg::ClipMinFull;
                end
            end
            default: begin
            end
        endcase
        if (mute) begin
            v = '0;
        end
        return v[OW-1:0];
    endfunction

    // Configuration registers.
    logic [7:0] r_master_volume;
    logic [2:0] r_boost_level;
    logic [7:0] r_clip_mode;
    logic       r_mute;

    // Item registers.
    logic signed [OW-1:0]           r_sample;
    logic [scmix_pkg::VolW-1:0]     r_vol, r_gain, r_pan;

    logic signed [scmix_pkg::AccW-1:0] r_s;
    logic [SW-1:0]                  r_left_sum, r_right_sum;
    logic [SW-1:0]                  r_prod;
    logic [OW-1:0]                  r_left_res;
    logic                           r_out_valid;
    logic [OW-1:0]                  r_left_out, r_right_out;

    logic signed [SW-1:0]              w_mul_a;
    logic signed [BW-1:0]              w_mul_b;
    logic signed [scmix_pkg::ProdW-1:0] w_prod;
    logic [SW-1:0]                     w_p32;
    logic signed [SW-1:0]              w_scaled;

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_left_out     = r_left_out;
    assign o_right_out    = r_right_out;

    // Operand select for the one shared multiplier.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (i_cmd.op)
            scmix_pkg::OP_VOL: begin
                w_mul_a = SW'(r_sample);
                w_mul_b = {2'b00, r_vol};
            end
            scmix_pkg::OP_GAIN: begin
                w_mul_a = SW'(r_s);
                w_mul_b = {2'b00, r_gain};
            end
            scmix_pkg::OP_PANR: begin
                w_mul_a = SW'(r_s);
                w_mul_b = {2'b00, r_pan};
            end
            scmix_pkg::OP_PANL: begin
                w_mul_a = SW'(r_s);
                w_mul_b = scmix_pkg::UnityWeight - {2'b00, r_pan};
            end
            scmix_pkg::OP_FINL: begin
                w_mul_a = r_left_sum;
                w_mul_b = {2'b00, r_master_volume};
            end
            scmix_pkg::OP_FINR: begin
                w_mul_a = r_right_sum;
                w_mul_b = {2'b00, r_master_volume};
            end
            scmix_pkg::OP_NONE, scmix_pkg::OP_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    assign w_prod   = w_mul_a * w_mul_b;
    assign w_p32    = w_prod[SW-1:0];
    assign w_scaled = $signed(w_p32) >>> scmix_pkg::FracSh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_volume <= '0;
            r_boost_level   <= '0;
            r_clip_mode     <= '0;
            r_mute          <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (scmix_pkg::t_cfg_idx'(i_cfg_index))
                scmix_pkg::CFG_MASTER_VOLUME: r_master_volume <= i_cfg_data;
                scmix_pkg::CFG_BOOST_LEVEL:   r_boost_level   <= i_cfg_data[2:0];
                scmix_pkg::CFG_CLIP_MODE:     r_clip_mode     <= i_cfg_data;
                scmix_pkg::CFG_MUTE:          r_mute          <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
            r_vol    <= i_channel_volume;
            r_gain   <= i_channel_gain;
            r_pan    <= i_pan_position;
        end
        if (i_cmd.op == scmix_pkg::OP_VOL || i_cmd.op == scmix_pkg::OP_GAIN) begin
            r_s <= w_scaled[scmix_pkg::AccW-1:0];
        end
        if (i_cmd.op == scmix_pkg::OP_FINL || i_cmd.op == scmix_pkg::OP_FINR) begin
            r_prod <= w_p32;
        end
        if (i_cmd.op == scmix_pkg::OP_FINR) begin
            r_left_res <= finish_word(r_prod, r_boost_level, r_clip_mode, r_mute);
        end
        if (i_cmd.op == scmix_pkg::OP_EMIT) begin
            r_left_out  <= r_left_res;
            r_right_out <= finish_word(r_prod, r_boost_level, r_clip_mode, r_mute);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_sum  <= '0;
            r_right_sum <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == scmix_pkg::OP_PANR) begin
                r_right_sum <= r_right_sum + w_scaled;
            end
            if (i_cmd.op == scmix_pkg::OP_PANL) begin
                r_left_sum <= r_left_sum + w_scaled;
            end
            if (i_cmd.op == scmix_pkg::OP_EMIT) begin
                r_left_sum  <= '0;
                r_right_sum <= '0;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `SCMIX_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, i_cmd.op == scmix_pkg::OP_EMIT, o_sts.out_free)
    `SCMIX_ASSERT_NXT(a_emit_clears, i_clk, i_rst_n, i_cmd.op == scmix_pkg::OP_EMIT, r_left_sum == '0 && r_right_sum == '0)
    `SCMIX_ASSERT_IMP(a_valid_src, i_clk, i_rst_n, $rose(r_out_valid), $past(i_cmd.op) == scmix_pkg::OP_EMIT)

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the stereo channel mixer with clip limiter.
module tb;
    import scmix_pkg::*;

    localparam int RANDOM_WORDS = 1550;
    localparam int STALL_LIMIT  = 4000;   // cycles with no word moving on either side
    localparam int SETTLE_HOLD  = 8;      // idle cycles waited after the last expected result
    localparam logic [7:0] CLIP_WRAP     = 8'd0;
    localparam logic [7:0] CLIP_WRAP_ALT = 8'hFF;

    typedef struct {
        logic signed [15:0] sample;
        logic [7:0]         vol;
        logic [7:0]         gain;
        logic [7:0]         pan;
        logic               active;
        logic               last;
    } chan_word_t;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } mix_result_t;

    typedef enum { ROW_WORD, ROW_REG } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        t_cfg_idx    reg_idx;
        logic [7:0]  reg_val;
        chan_word_t  w;
        bit          typed;
        mix_result_t res;
    } plan_row_t;

    typedef enum { STALL_NONE, STALL_COIN, STALL_PATTERN } stall_style_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic signed [15:0] i_sample = '0;
    logic [7:0]        i_channel_volume = '0;
    logic [7:0]        i_channel_gain = '0;
    logic [7:0]        i_pan_position = '0;
    logic              i_active = 1'b0;
    logic              i_last_channel = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic signed [15:0] o_left_out;
    logic signed [15:0] o_right_out;
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_index = '0;
    logic [7:0]        i_cfg_data = '0;

    stereo_channel_mixer_with_clip dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_sample         (i_sample),
        .i_channel_volume (i_channel_volume),
        .i_channel_gain   (i_channel_gain),
        .i_pan_position   (i_pan_position),
        .i_active         (i_active),
        .i_last_channel   (i_last_channel),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_left_out       (o_left_out),
        .o_right_out      (o_right_out),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the registers and the frame sums
    logic [7:0]  cfg_master = '0;
    logic [2:0]  cfg_boost = '0;
    logic [7:0]  cfg_clip = '0;
    logic        cfg_mute = 1'b0;
    logic [31:0] mix_left = '0;
    logic [31:0] mix_right = '0;

    mix_result_t pending_mix[$];
    plan_row_t   plan[$];
    int          mismatches = 0;
    int          burst_left = 0;
    bit          steady_feed = 1'b0;

    // Arithmetic shift right of a 32-bit two's complement pattern
    function automatic logic [31:0] sra(input logic [31:0] v, input int unsigned sh);
        return $signed(v) >>> sh;
    endfunction

    function automatic logic signed [31:0] clamp_to(input logic signed [31:0] v,
                                                   input logic signed [31:0] lo,
                                                   input logic signed [31:0] hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Master volume, boost shift, clip and mute applied to one frame sum
    function automatic logic signed [15:0] master_stage(input logic [31:0] sum);
        logic [31:0]        v;
        logic signed [31:0] sv;
        v = sum * {24'd0, cfg_master};
        sv = sra(v, 7 - cfg_boost);
        case (cfg_clip)
            CLIP_75:   sv = clamp_to(sv, -ClipMax75, ClipMax75);
            CLIP_875:  sv = clamp_to(sv, -ClipMax875, ClipMax875);
            CLIP_FULL: sv = clamp_to(sv, ClipMinFull, ClipMaxFull);
            default:   ;
        endcase
        if (cfg_mute) sv = '0;
        return sv[15:0];
    endfunction

    // Fold one channel word into the sums; close the frame on the last one
    function automatic bit mix_channel(input chan_word_t w, output mix_result_t res);
        logic [31:0] s;
        res.left = '0;
        res.right = '0;
        if (w.active) begin
            s = sra({{16{w.sample[15]}}, w.sample} * {24'd0, w.vol}, 7);
            s = sra(s * {24'd0, w.gain}, 7);
            mix_right = mix_right + sra(s * {24'd0, w.pan}, 7);
            // pan above 128 makes this weight negative; it wraps like the sums
            mix_left = mix_left + sra(s * (32'd128 - {24'd0, w.pan}), 7);
        end
        if (!w.last) return 1'b0;
        res.left = master_stage(mix_left);
        res.right = master_stage(mix_right);
        mix_left = '0;
        mix_right = '0;
        return 1'b1;
    endfunction

    function automatic void plan_word(input logic signed [15:0] sample, input logic [7:0] vol,
                                      input logic [7:0] gain, input logic [7:0] pan,
                                      input logic active, input logic last,
                                      input bit typed = 1'b0,
                                      input logic signed [15:0] left = '0,
                                      input logic signed [15:0] right = '0);
        plan_row_t r;
        r.kind = ROW_WORD;
        r.reg_idx = CFG_MASTER_VOLUME;
        r.reg_val = '0;
        r.w = '{sample, vol, gain, pan, active, last};
        r.typed = typed;
        r.res = '{left, right};
        plan.push_back(r);
    endfunction

    function automatic void plan_reg(input t_cfg_idx idx, input logic [7:0] val);
        plan_row_t r;
        r.kind = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        r.w = '{'0, '0, '0, '0, 1'b0, 1'b0};
        r.typed = 1'b0;
        r.res = '{'0, '0};
        plan.push_back(r);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd128;
            default: return 8'($urandom);
        endcase
    endfunction

    // Drop valid, wait for every expected word, then let the block go quiet
    task automatic settle_block();
        i_in_valid = 1'b0;
        while (pending_mix.size() != 0) @(negedge i_clk);
        repeat (SETTLE_HOLD) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] val);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        case (idx)
            CFG_MASTER_VOLUME: cfg_master = val;
            CFG_BOOST_LEVEL:   cfg_boost = val[2:0];
            CFG_CLIP_MODE:     cfg_clip = val;
            CFG_MUTE:          cfg_mute = val[0];
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Present one word at a falling edge, hold it through stalls, predict on accept
    task automatic send_word(input chan_word_t w, input bit typed, input mix_result_t typed_res);
        mix_result_t res;
        int          gap;
        i_sample = w.sample;
        i_channel_volume = w.vol;
        i_channel_gain = w.gain;
        i_pan_position = w.pan;
        i_active = w.active;
        i_last_channel = w.last;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        if (mix_channel(w, res)) pending_mix.push_back(typed ? typed_res : res);
        @(negedge i_clk);
        if (!steady_feed) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    i_in_valid = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end else begin
                burst_left--;
            end
        end
    endtask

    // Receiver stall: switch style after a random span; patterns never stall forever
    stall_style_t stall_style = STALL_NONE;
    int           stall_span = 0;
    logic [15:0]  stall_bits = '0;

    always @(negedge i_clk) begin
        if (stall_span == 0) begin
            stall_span = $urandom_range(20, 80);
            stall_style = stall_style_t'($urandom_range(0, 2));
            stall_bits = 16'($urandom);
            stall_bits[0] = 1'b0;
        end else begin
            stall_span--;
        end
        case (stall_style)
            STALL_NONE: i_out_stall = 1'b0;
            STALL_COIN: i_out_stall = 1'($urandom_range(0, 1));
            default: begin
                i_out_stall = stall_bits[0];
                stall_bits = {stall_bits[0], stall_bits[15:1]};
            end
        endcase
    end

    // Compare every accepted output word with the oldest prediction
    always @(posedge i_clk) begin : check_out
        mix_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_mix.size() == 0) begin
                $error("output word with nothing expected: left_out %0d right_out %0d",
                       o_left_out, o_right_out);
                mismatches++;
            end else begin
                want = pending_mix.pop_front();
                if (o_left_out !== want.left) begin
                    $error("left_out: expected %0d, got %0d", want.left, o_left_out);
                    mismatches++;
                end
                if (o_right_out !== want.right) begin
                    $error("right_out: expected %0d, got %0d", want.right, o_right_out);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if no word moves for too long
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("stereo_channel_mixer_with_clip verification failed");
            $finish;
        end
    end

    initial begin : main_seq
        plan_row_t   r;
        chan_word_t  w;
        mix_result_t none;
        int          random_words;
        int          frame_len;
        bit          overload;
        logic signed [15:0] hot_sample;
        logic [7:0]  hot_pan;

        none = '{'0, '0};
        random_words = 0;

        // Directed: master volume is zero out of reset, so the first frame is silent
        plan_word(-16'sd32768, 8'd255, 8'd255, 8'd0, 1'b1, 1'b1, 1'b1, 16'sd0, 16'sd0);
        // Full boost and loudest channel drive the clamps; pan 0 and 128 pick one side
        plan_reg(CFG_MASTER_VOLUME, 8'd255);
        plan_reg(CFG_BOOST_LEVEL, 8'd7);
        plan_reg(CFG_CLIP_MODE, CLIP_FULL);
        plan_word(16'sd32767, 8'd255, 8'd255, 8'd0, 1'b1, 1'b1, 1'b1, 16'sd32767, 16'sd0);
        plan_word(-16'sd32768, 8'd255, 8'd255, 8'd128, 1'b1, 1'b1, 1'b1, 16'sd0, -16'sd32768);
        plan_reg(CFG_CLIP_MODE, CLIP_75);
        plan_word(16'sd32767, 8'd255, 8'd255, 8'd0, 1'b1, 1'b1, 1'b1, 16'sd24576, 16'sd0);
        plan_word(-16'sd32768, 8'd255, 8'd255, 8'd128, 1'b1, 1'b1, 1'b1, 16'sd0, -16'sd24576);
        plan_reg(CFG_CLIP_MODE, CLIP_875);
        plan_word(16'sd32767, 8'd255, 8'd255, 8'd128, 1'b1, 1'b1, 1'b1, 16'sd0, 16'sd28672);
        plan_word(-16'sd32768, 8'd255, 8'd255, 8'd0, 1'b1, 1'b1, 1'b1, -16'sd28672, 16'sd0);
        plan_reg(CFG_MUTE, 8'd1);
        plan_word(16'sd32767, 8'd255, 8'd255, 8'd64, 1'b1, 1'b1, 1'b1, 16'sd0, 16'sd0);
        // Unity master, wrap mode: a mixed frame with an inactive channel and pan past 128
        plan_reg(CFG_MUTE, 8'd0);
        plan_reg(CFG_CLIP_MODE, CLIP_WRAP);
        plan_reg(CFG_MASTER_VOLUME, 8'd128);
        plan_reg(CFG_BOOST_LEVEL, 8'd0);
        plan_word(16'sd1000, 8'd128, 8'd128, 8'd64, 1'b1, 1'b0);
        plan_word(-16'sd5000, 8'd200, 8'd50, 8'd255, 1'b1, 1'b0);
        plan_word(16'sd12345, 8'd255, 8'd255, 8'd200, 1'b0, 1'b0);
        plan_word(16'sd7, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1);
        // Inactive last channel still closes an empty frame
        plan_word(16'sd32767, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 1'b1, 16'sd0, 16'sd0);
        plan_word(16'sd32767, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
        plan_reg(CFG_CLIP_MODE, CLIP_WRAP_ALT);
        plan_reg(CFG_BOOST_LEVEL, 8'd3);
        plan_reg(CFG_MASTER_VOLUME, 8'd200);
        plan_word(-16'sd32768, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
        // Alternating bit patterns on the sample, volume, gain and pan fields
        plan_word(16'sh5555, 8'hAA, 8'h55, 8'hAA, 1'b1, 1'b0);
        plan_word(16'shAAAA, 8'h55, 8'hAA, 8'h55, 1'b1, 1'b1);

        // Hold reset, then release it at a falling edge
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            r = plan[i];
            if (r.kind == ROW_REG) begin
                settle_block();
                write_reg(r.reg_idx, r.reg_val);
            end else begin
                send_word(r.w, r.typed, r.res);
            end
        end

        // Random phases: fresh settings, then whole frames with random content
        while (random_words < RANDOM_WORDS) begin
            settle_block();
            case ($urandom_range(0, 7))
                0:       write_reg(CFG_MASTER_VOLUME, 8'd0);
                1:       write_reg(CFG_MASTER_VOLUME, 8'd255);
                2:       write_reg(CFG_MASTER_VOLUME, 8'd128);
                default: write_reg(CFG_MASTER_VOLUME, 8'($urandom));
            endcase
            write_reg(CFG_BOOST_LEVEL, 8'($urandom_range(0, 7)));
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_CLIP_MODE, CLIP_FULL);
                1:       write_reg(CFG_CLIP_MODE, CLIP_875);
                2:       write_reg(CFG_CLIP_MODE, CLIP_75);
                3:       write_reg(CFG_CLIP_MODE, CLIP_WRAP);
                4:       write_reg(CFG_CLIP_MODE, CLIP_WRAP_ALT);
                default: write_reg(CFG_CLIP_MODE, 8'($urandom));
            endcase
            write_reg(CFG_MUTE, ($urandom_range(0, 7) == 0) ? 8'd1 : 8'd0);
            steady_feed = ($urandom_range(0, 3) == 0);

            repeat ($urandom_range(3, 10)) begin
                // Hold off now and then until the output side has caught up
                if ($urandom_range(0, 29) == 0) settle_block();
                // A long frame of loud channels can overflow the master product
                overload = ($urandom_range(0, 39) == 0);
                if (overload) begin
                    frame_len = $urandom_range(33, 40);
                    hot_sample = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
                    hot_pan = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                end else if ($urandom_range(0, 3) == 0) begin
                    frame_len = $urandom_range(5, 16);
                end else begin
                    frame_len = $urandom_range(1, 4);
                end
                for (int k = 0; k < frame_len; k++) begin
                    if (overload) begin
                        w = '{hot_sample, 8'd255, 8'd255, hot_pan, 1'b1, 1'b0};
                    end else begin
                        case ($urandom_range(0, 7))
                            0:       w.sample = 16'sd32767;
                            1:       w.sample = -16'sd32768;
                            default: w.sample = 16'($urandom);
                        endcase
                        w.vol = pick_byte();
                        w.gain = pick_byte();
                        w.pan = pick_byte();
                        w.active = ($urandom_range(0, 7) != 0);
                    end
                    w.last = (k == frame_len - 1);
                    send_word(w, 1'b0, none);
                    random_words++;
                end
            end
        end

        settle_block();
        if (mismatches == 0 && pending_mix.size() == 0) begin
            $display("stereo_channel_mixer_with_clip verification clean");
        end else begin
            $display("stereo_channel_mixer_with_clip verification failed");
        end
        $finish;
    end

endmodule
